### src/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants of the 4x4 fixed-point matrix multiplier:
// operation codes, the microcode control word, and the status and result
// groups passed between the sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

  localparam int DATA_W  = 32;   // element width, signed fixed point
  localparam int IDX_W   = 2;    // width of the row and column fields
  localparam int TDATA_W = 40;   // row, col and value padded to whole bytes
  localparam int STEP_W  = 4;    // microcode step counter width

  typedef enum logic [1:0] {
    OP_WR_LEFT  = 2'd0,
    OP_WR_RIGHT = 2'd1,
    OP_MUL      = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_MUL   = 3'd2,
    COND_K_MORE   = 3'd3,
    COND_OUT_BUSY = 3'd4,
    COND_C_MORE   = 3'd5,
    COND_R_LAST   = 3'd6
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  // One microcode word.
  typedef struct packed {
    logic  ready;    // take an input word
    logic  clr;      // clear the row, column and term counters
    logic  ld_row;   // read one left element into the row cache
    logic  term;     // issue one product term of the current element
    logic  emit;     // hand the finished element to the output register
    logic  r_inc;    // advance to the next row
    cond_t cond;     // jump condition
    step_t target;   // jump target
  } ctrl_t;

  typedef struct packed {
    logic k_last;    // term counter is at its last value
    logic c_more;    // column counter has not wrapped
    logic r_last;    // row counter is at its last value
  } dp_status_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] product;
    logic                     sat;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

### src/matrix_multiply_4x4.sv
// A write word (op 0 or 1) is taken and produces nothing. A multiply word runs
// through every element of the product, one product term per cycle through the
// single shared multiplier, and each row adds a row-cache load.
// No new word is taken while a multiply is running. Reset loads the identity into
// the left matrix and zero into the right one, with no clearing pass.
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// Fixed-point DIM x DIM matrix multiplier driven by a microcoded sequencer.
// The product replaces the left matrix and streams out in row-major order.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_4x4 #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire [mm4_pkg::TDATA_W-1:0]    s_tdata,   // row[1:0], col[3:2], value[35:4]
  input  wire [1:0]                     s_tuser,   // op[1:0]
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [mm4_pkg::TDATA_W-1:0]   m_tdata,   // out_row[1:0], out_col[3:2], product[35:4]
  output logic [0:0]                    m_tuser,   // saturated[0]
  output logic                          m_tlast
);

  import mm4_pkg::*;

  ctrl_t      ctrl;
  dp_status_t status;
  res_t       res;
  res_t       out_res;
  logic       in_fire;
  logic       mul_req;
  logic       out_busy;
  logic       emit_fire;

  assign s_tready  = ctrl.ready;
  assign in_fire   = s_tvalid && s_tready;
  assign mul_req   = s_tvalid && (s_tuser == OP_MUL);
  assign out_busy  = m_tvalid && !m_tready;
  assign emit_fire = ctrl.emit && !out_busy;

  mm4_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .mul_req  (mul_req),
    .out_busy (out_busy),
    .status   (status),
    .ctrl     (ctrl)
  );

  mm4_datapath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_fire   (in_fire),
    .in_op     (s_tuser),
    .in_row    (s_tdata[1:0]),
    .in_col    (s_tdata[3:2]),
    .in_value  (s_tdata[35:4]),
    .emit_fire (emit_fire),
    .status    (status),
    .res       (res)
  );

  // Output register: the next element is loaded as the current one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {(TDATA_W - 36)'(0), out_res.product, out_res.col, out_res.row};
  assign m_tuser = out_res.sat;
  assign m_tlast = out_res.last;

  // A multiply word holds off further input until the product is done.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_MUL |=> !s_tready)
    else $error("input taken right after a multiply word");

  // The last word of a product is the bottom-right element.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[1:0] == 2'(DIM - 1) && m_tdata[3:2] == 2'(DIM - 1))
    else $error("last marker on an element other than the final one");

  // Nothing follows the last word of a product in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("output word right after the last element");

endmodule

`default_nettype wire

### src/mm4_seq.sv
// ----------------------------------------------------------------------------
// mm4_seq
// Microcode sequencer: a step counter addressing a read-only program whose
// control words drive the datapath, with conditional jumps on status flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_seq (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  mul_req,
  input  wire                  out_busy,
  input  mm4_pkg::dp_status_t  status,
  output mm4_pkg::ctrl_t       ctrl
);

  import mm4_pkg::*;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_LOAD   = 4'd1;
  localparam step_t STEP_LOADW  = 4'd2;
  localparam step_t STEP_TERM   = 4'd3;
  localparam step_t STEP_DRAIN1 = 4'd4;
  localparam step_t STEP_DRAIN2 = 4'd5;
  localparam step_t STEP_EMIT   = 4'd6;
  localparam step_t STEP_NEXTC  = 4'd7;
  localparam step_t STEP_NEXTR  = 4'd8;
  localparam step_t STEP_NEXTRW = 4'd9;

  step_t step;
  step_t step_next;
  logic  jump;

  function automatic ctrl_t rom(input step_t s);
    ctrl_t w;
    w        = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_IDLE;
    case (s)
      STEP_IDLE: begin
        w.ready  = 1'b1;
        w.clr    = 1'b1;
        w.cond   = COND_NO_MUL;
        w.target = STEP_IDLE;
      end
      STEP_LOAD: begin
        w.ld_row = 1'b1;
        w.cond   = COND_K_MORE;
        w.target = STEP_LOAD;
      end
      STEP_LOADW: begin
        w.cond = COND_NEVER;
      end
      STEP_TERM: begin
        w.term   = 1'b1;
        w.cond   = COND_K_MORE;
        w.target = STEP_TERM;
      end
      STEP_DRAIN1: begin
        w.cond = COND_NEVER;
      end
      STEP_DRAIN2: begin
        w.cond = COND_NEVER;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      STEP_NEXTC: begin
        w.cond   = COND_C_MORE;
        w.target = STEP_TERM;
      end
      STEP_NEXTR: begin
        w.r_inc  = 1'b1;
        w.cond   = COND_R_LAST;
        w.target = STEP_IDLE;
      end
      STEP_NEXTRW: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_LOAD;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  assign ctrl = rom(step);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_MUL:   jump = !mul_req;
      COND_K_MORE:   jump = !status.k_last;
      COND_OUT_BUSY: jump = out_busy;
      COND_C_MORE:   jump = status.c_more;
      COND_R_LAST:   jump = status.r_last;
      default:       jump = 1'b0;
    endcase
    step_next = jump ? ctrl.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

### src/mm4_datapath.sv
// ----------------------------------------------------------------------------
// mm4_datapath
// Matrix storage, index counters, row cache, one shared multiplier and the
// accumulator with the final shift and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_datapath #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  mm4_pkg::ctrl_t                      ctrl,
  input  wire                                 in_fire,
  input  wire [1:0]                           in_op,
  input  wire [mm4_pkg::IDX_W-1:0]            in_row,
  input  wire [mm4_pkg::IDX_W-1:0]            in_col,
  input  wire signed [mm4_pkg::DATA_W-1:0]    in_value,
  input  wire                                 emit_fire,
  output mm4_pkg::dp_status_t                 status,
  output mm4_pkg::res_t                       res
);

  import mm4_pkg::*;

  localparam int IW    = $clog2(DIM);
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = 2 * DATA_W + $clog2(DIM);
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  function automatic logic [AW-1:0] addr(input int a, input int b);
    return AW'(a * DIM + b);
  endfunction

  // Counters
  logic [IW-1:0] r;
  logic [IW-1:0] c;
  logic [IW-1:0] k;
  logic          k_last;

  assign k_last = (k == IW'(DIM - 1));
  assign status.k_last = k_last;
  assign status.c_more = (c != '0);
  assign status.r_last = (r == IW'(DIM - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
      c <= '0;
      k <= '0;
    end else if (ctrl.clr) begin
      r <= '0;
      c <= '0;
      k <= '0;
    end else begin
      if (ctrl.ld_row || ctrl.term) begin
        k <= k_last ? '0 : k + IW'(1);
      end
      if (emit_fire) begin
        c <= (c == IW'(DIM - 1)) ? '0 : c + IW'(1);
      end
      if (ctrl.r_inc) begin
        r <= status.r_last ? '0 : r + IW'(1);
      end
    end
  end

  // Write decode for input words. Elements outside the matrix are dropped.
  logic in_range;
  logic wr_left;
  logic wr_right;

  assign in_range = (int'(in_row) < DIM) && (int'(in_col) < DIM);
  assign wr_left  = (in_fire && in_range && in_op == OP_WR_LEFT) || emit_fire;
  assign wr_right = in_fire && in_range && in_op == OP_WR_RIGHT;

  // Left matrix. The product is written back in place while the rest of the
  // row is still taken from the row cache.
  logic [DATA_W-1:0]        left_mem [DEPTH];
  logic [DEPTH-1:0]         left_vld;
  logic [AW-1:0]            left_waddr;
  logic [DATA_W-1:0]        left_wdata;
  logic [DATA_W-1:0]        left_q;
  logic                     left_q_vld;
  logic                     left_q_diag;
  logic signed [DATA_W-1:0] left_val;

  assign left_waddr = emit_fire ? addr(int'(r), int'(c)) : addr(int'(in_row), int'(in_col));
  assign left_wdata = emit_fire ? res.product : in_value;

  always_ff @(posedge clk) begin
    if (wr_left) begin
      left_mem[left_waddr] <= left_wdata;
    end
    left_q      <= left_mem[addr(int'(r), int'(k))];
    left_q_diag <= (r == k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_vld   <= '0;
      left_q_vld <= 1'b0;
    end else begin
      if (wr_left) begin
        left_vld[left_waddr] <= 1'b1;
      end
      left_q_vld <= left_vld[addr(int'(r), int'(k))];
    end
  end

  // Entries never written read as the identity matrix.
  assign left_val = left_q_vld ? left_q : (left_q_diag ? ONE : '0);

  // Right matrix, reading as zero until written.
  logic [DATA_W-1:0]        right_mem [DEPTH];
  logic [DEPTH-1:0]         right_vld;
  logic [AW-1:0]            right_waddr;
  logic [AW-1:0]            right_raddr;
  logic [DATA_W-1:0]        right_q;
  logic                     right_q_vld;
  logic signed [DATA_W-1:0] right_val;

  assign right_waddr = addr(int'(in_row), int'(in_col));
  assign right_raddr = addr(int'(k), int'(c));

  always_ff @(posedge clk) begin
    if (wr_right) begin
      right_mem[right_waddr] <= in_value;
    end
    right_q <= right_mem[right_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_vld   <= '0;
      right_q_vld <= 1'b0;
    end else begin
      if (wr_right) begin
        right_vld[right_waddr] <= 1'b1;
      end
      right_q_vld <= right_vld[right_raddr];
    end
  end

  assign right_val = right_q_vld ? right_q : '0;

  // Row cache: filled by shifting in, then rotated once per term so that
  // the current left element always sits in entry zero.
  logic signed [DATA_W-1:0] row_cache [DIM];
  logic signed [DATA_W-1:0] lhs_q;
  logic                     ld_d1;

  always_ff @(posedge clk) begin
    if (ld_d1) begin
      for (int i = 0; i < DIM - 1; i++) begin
        row_cache[i] <= row_cache[i + 1];
      end
      row_cache[DIM - 1] <= left_val;
    end else if (ctrl.term) begin
      for (int i = 0; i < DIM - 1; i++) begin
        row_cache[i] <= row_cache[i + 1];
      end
      row_cache[DIM - 1] <= row_cache[0];
    end
    if (ctrl.term) begin
      lhs_q <= row_cache[0];
    end
  end

  // Term pipeline: read, multiply, accumulate.
  logic                     term_d1;
  logic                     first_d1;
  logic                     mul_d2;
  logic                     first_d2;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_d1    <= 1'b0;
      term_d1  <= 1'b0;
      first_d1 <= 1'b0;
      mul_d2   <= 1'b0;
      first_d2 <= 1'b0;
    end else begin
      ld_d1    <= ctrl.ld_row;
      term_d1  <= ctrl.term;
      first_d1 <= ctrl.term && (k == '0);
      mul_d2   <= term_d1;
      first_d2 <= first_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (term_d1) begin
      prod <= lhs_q * right_val;
    end
    if (mul_d2) begin
      acc <= first_d2 ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // Shift out the fraction and clip to the 32-bit range.
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-DATA_W:0]     upper;
  logic                      fits;

  assign shifted = acc >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:DATA_W-1];
  assign fits    = (&upper) || !(|upper);

  always_comb begin
    res.row  = IDX_W'(r);
    res.col  = IDX_W'(c);
    res.sat  = !fits;
    res.last = status.r_last && (c == IW'(DIM - 1));
    if (fits) begin
      res.product = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      res.product = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res.product = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire
